>>> hw/rtl/binary_max_heap_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_defines
// assertion macros used by the priority queue top level
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define BHPQ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bhpq assertion failed");

// next-cycle implication
`define BHPQ_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bhpq assertion failed");

`endif

>>> hw/rtl/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared types and constants of the binary max heap priority queue
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int DEPTH_DEF = 128;
	localparam int ENTRY_W   = 64;
	localparam int ADDR_W    = 3;

	localparam logic [7:0] CAP_RESET = 8'd100;
	localparam logic       REG_CAP   = 1'b0;

	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_DEQ  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVF   = 2'd1;
	localparam logic [1:0] ST_UNF   = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [31:0] val;
		logic [31:0] pri;
	} entry_t;

endpackage

>>> hw/rtl/bhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module bhpq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

>>> hw/rtl/bhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_ctrl
// request sequencer: sift up and sift down over the heap memory
// ----------------------------------------------------------------------------
module bhpq_ctrl #(
	parameter int DEPTH = bhpq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         cap,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] value,
	input  logic signed [31:0] priority_req,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic signed [31:0] out_priority,
	output logic [7:0]         occupancy
);

	import bhpq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = AW + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_DQ, S_PK, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_RESP
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   pos_q;
	entry_t          ent_q;
	entry_t          res_ent_q;
	logic [1:0]      res_st_q;
	logic            out_valid_q;
	logic [1:0]      status_q;
	entry_t          out_ent_q;
	logic [7:0]      occ_q;

	logic            we;
	logic [AW-1:0]   waddr;
	entry_t          wdata;
	logic [AW-1:0]   raddr0;
	logic [AW-1:0]   raddr1;
	logic [ENTRY_W-1:0] rdata0;
	logic [ENTRY_W-1:0] rdata1;
	entry_t          rd0;
	entry_t          rd1;

	logic [IW-1:0]   cnt_ext;
	logic [IW-1:0]   lc;
	logic [IW-1:0]   rc;
	logic            lc_ok;
	logic            rc_ok;
	logic [AW-1:0]   par;
	logic [AW-1:0]   last;
	logic [CW-1:0]   cnt_m1;
	logic            full;
	logic            up_win;
	logic            l_win;
	logic            r_win;
	logic [31:0]     best_pri;
	logic [CW+7:0]   occ_ext;

	assign rd0     = entry_t'(rdata0);
	assign rd1     = entry_t'(rdata1);
	assign cnt_ext = IW'(cnt_q);
	assign lc      = {1'b0, pos_q, 1'b1};
	assign rc      = lc + IW'(1);
	assign lc_ok   = lc < cnt_ext;
	assign rc_ok   = rc < cnt_ext;
	assign par     = AW'((pos_q - AW'(1)) >> 1);
	assign cnt_m1  = cnt_q - CW'(1);
	assign last    = cnt_m1[AW-1:0];
	assign full    = ({8'b0, cnt_q} >= {{CW{1'b0}}, cap}) || (cnt_q >= DEPTH_C);
	assign up_win  = $signed(ent_q.pri) > $signed(rd0.pri);
	assign l_win   = $signed(rd0.pri) > $signed(ent_q.pri);
	assign best_pri = l_win ? rd0.pri : ent_q.pri;
	assign r_win   = rc_ok && ($signed(rd1.pri) > $signed(best_pri));
	assign occ_ext = {8'b0, cnt_q};

	// memory port drive
	always_comb begin
		we     = 1'b0;
		waddr  = pos_q;
		wdata  = ent_q;
		raddr0 = '0;
		raddr1 = last;
		case (state_q)
			S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					raddr0 = par;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (up_win) begin
					wdata = rd0;
				end
			end
			S_DN_RD: begin
				we     = !lc_ok;
				raddr0 = lc[AW-1:0];
				raddr1 = rc[AW-1:0];
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (r_win) begin
					wdata = rd1;
				end else if (l_win) begin
					wdata = rd0;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			ent_q       <= '0;
			res_ent_q   <= '0;
			res_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			out_ent_q   <= '0;
			occ_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_ent_q <= '0;
						unique case (req_type)
							REQ_ENQ: begin
								if (full) begin
									res_st_q <= ST_OVF;
									state_q  <= S_RESP;
								end else begin
									res_st_q <= ST_OK;
									ent_q    <= '{val: value, pri: priority_req};
									pos_q    <= cnt_q[AW-1:0];
									cnt_q    <= cnt_q + CW'(1);
									state_q  <= S_UP_RD;
								end
							end
							REQ_DEQ: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_UNF;
									state_q  <= S_RESP;
								end else begin
									res_st_q <= ST_OK;
									state_q  <= S_DQ;
								end
							end
							REQ_PEEK: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_RESP;
								end else begin
									res_st_q <= ST_OK;
									state_q  <= S_PK;
								end
							end
							default: begin
								res_st_q <= ST_OK;
								state_q  <= S_RESP;
							end
						endcase
					end
				end
				S_DQ: begin
					res_ent_q <= rd0;
					ent_q     <= rd1;
					cnt_q     <= cnt_m1;
					pos_q     <= '0;
					state_q   <= (cnt_m1 == '0) ? S_RESP : S_DN_RD;
				end
				S_PK: begin
					res_ent_q <= rd0;
					state_q   <= S_RESP;
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_RESP : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_win) begin
						pos_q   <= par;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_DN_RD: begin
					state_q <= lc_ok ? S_DN_CMP : S_RESP;
				end
				S_DN_CMP: begin
					if (r_win) begin
						pos_q   <= rc[AW-1:0];
						state_q <= S_DN_RD;
					end else if (l_win) begin
						pos_q   <= lc[AW-1:0];
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_st_q;
						out_ent_q   <= res_ent_q;
						occ_q       <= occ_ext[7:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	bhpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_value    = out_ent_q.val;
	assign out_priority = out_ent_q.pri;
	assign occupancy    = occ_q;

endmodule

>>> hw/rtl/binary_max_heap_priority_queue.sv
// errors and unused-kind requests go straight to the response; peek reads the root
// enqueue climbs from the new slot until the root or an equal or higher parent
// dequeue moves the last entry to the root and sinks it until no child is higher
// one request at a time: in_stall stays high until the result is registered
// each heap level costs one registered read of the heap ram and one compare
// reset: queue empty, capacity limit 100, heap ram contents left as they are
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// max priority queue held as a binary heap in one ram, apb capacity register
// ----------------------------------------------------------------------------
`include "binary_max_heap_priority_queue_defines.svh"

module binary_max_heap_priority_queue #(
	parameter int DEPTH = bhpq_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bhpq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic signed [31:0]        value,
	input  logic signed [31:0]        priority_req,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic signed [31:0]        out_value,
	output logic signed [31:0]        out_priority,
	output logic [7:0]                occupancy
);

	import bhpq_pkg::*;

	logic [7:0] cap_q;
	logic       reg_idx;
	logic       cfg_wr;

	assign reg_idx = paddr[ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_CAP);
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_CAP) ? {24'b0, cap_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[7:0];
		end
	end

	bhpq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cap          (cap_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.value        (value),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_value    (out_value),
		.out_priority (out_priority),
		.occupancy    (occupancy)
	);

	// an accepted beat keeps the sequencer busy in the cycle after it
	`BHPQ_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// a new result only comes out of a busy sequencer
	`BHPQ_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))
	// empty-queue results carry no entry and zero occupancy
	`BHPQ_ASSERT_NOW(a_empty_result, clk, arst_n,
		out_valid && (status == ST_UNF || status == ST_EMPTY),
		occupancy == 8'd0 && out_value == 32'sd0 && out_priority == 32'sd0)

endmodule

>>> tb/sv/binary_max_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_tb
// Self-checking bench for the heap priority queue. Requests are sent on the
// valid/stall input channel, and each accepted beat is also run through a
// behavioral heap inside the bench. Result beats are compared in order
// against that expectation. A short directed table comes first: the empty
// cases, priority extremes, ties, capacity zero, one and the full depth, and
// a write to an unused register. Random phases follow at several capacity
// settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_tb;
	import bhpq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int LIMIT_CYCLES = 2000;

	localparam logic [1:0]        REQ_NONE   = 2'd3;
	localparam logic [ADDR_W-1:0] ADDR_CAP   = {REG_CAP, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_SPARE = 3'd4;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] v;
		logic [31:0] p;
		logic [7:0]  occ;
	} pq_result_t;

	typedef struct {
		bit                cfg;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
		logic [1:0]        kind;
		logic [31:0]       val;
		logic [31:0]       pri;
		bit                typed;
		pq_result_t        want;
	} stim_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [ADDR_W-1:0]  paddr        = '0;
	logic [31:0]        pwdata       = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type     = REQ_ENQ;
	logic signed [31:0] value        = '0;
	logic signed [31:0] priority_req = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic signed [31:0] out_priority;
	logic [7:0]         occupancy;

	entry_t      heap_model [DEPTH];
	int unsigned held       = 0;
	int unsigned peak_held  = 0;
	logic [7:0]  cap_reg    = CAP_RESET;
	pq_result_t  results_due [$];
	pq_result_t  due_front;
	stim_row_t   directed [$];
	int          idle_pct   = 25;
	int          err_cnt    = 0;
	int          quiet_cnt  = 0;
	int          kind_seen [4];
	int          status_seen [4];

	binary_max_heap_priority_queue #(.DEPTH(DEPTH)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.value        (value),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_value    (out_value),
		.out_priority (out_priority),
		.occupancy    (occupancy)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void check_field(input string fname, input logic [31:0] exp,
		input logic [31:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected 0x%08h, got 0x%08h", fname, exp, act);
			err_cnt++;
		end
	endfunction

	function automatic void swap_model(input int unsigned a, input int unsigned b);
		entry_t tmp;
		tmp           = heap_model[a];
		heap_model[a] = heap_model[b];
		heap_model[b] = tmp;
	endfunction

	function automatic pq_result_t predict_pq(input logic [1:0] kind, input logic [31:0] v,
		input logic [31:0] p);
		pq_result_t  r;
		int unsigned lim, pos, par, lc, rc, top;
		bit          done;
		r    = '0;
		r.st = ST_OK;
		lim  = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		done = 1'b0;
		case (kind)
			REQ_ENQ: begin
				if (held >= lim) begin
					r.st = ST_OVF;
				end else begin
					heap_model[held] = entry_t'{val: v, pri: p};
					pos  = held;
					held = held + 1;
					while (pos > 0 && !done) begin
						par = (pos - 1) / 2;
						if ($signed(heap_model[pos].pri) > $signed(heap_model[par].pri)) begin
							swap_model(pos, par);
							pos = par;
						end else begin
							done = 1'b1;
						end
					end
				end
			end
			REQ_DEQ: begin
				if (held == 0) begin
					r.st = ST_UNF;
				end else begin
					r.v           = heap_model[0].val;
					r.p           = heap_model[0].pri;
					held          = held - 1;
					heap_model[0] = heap_model[held];
					pos           = 0;
					while (!done) begin
						lc  = 2 * pos + 1;
						rc  = lc + 1;
						top = pos;
						if (lc < held && $signed(heap_model[lc].pri) > $signed(heap_model[top].pri))
							top = lc;
						if (rc < held && $signed(heap_model[rc].pri) > $signed(heap_model[top].pri))
							top = rc;
						if (top == pos) begin
							done = 1'b1;
						end else begin
							swap_model(pos, top);
							pos = top;
						end
					end
				end
			end
			REQ_PEEK: begin
				if (held == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.v = heap_model[0].val;
					r.p = heap_model[0].pri;
				end
			end
			default: ;
		endcase
		if (held > peak_held)
			peak_held = held;
		r.occ = 8'(held);
		return r;
	endfunction

	function automatic stim_row_t row_req(input logic [1:0] kind, input logic [31:0] v,
		input logic [31:0] p);
		stim_row_t row;
		row       = '{default: '0};
		row.kind  = kind;
		row.val   = v;
		row.pri   = p;
		return row;
	endfunction

	function automatic stim_row_t row_chk(input logic [1:0] kind, input logic [31:0] v,
		input logic [31:0] p, input logic [1:0] st, input logic [31:0] ov,
		input logic [31:0] op, input logic [7:0] occ);
		stim_row_t row;
		row       = row_req(kind, v, p);
		row.typed = 1'b1;
		row.want  = '{st: st, v: ov, p: op, occ: occ};
		return row;
	endfunction

	function automatic stim_row_t row_cfg(input logic [ADDR_W-1:0] a, input logic [31:0] d);
		stim_row_t row;
		row      = '{default: '0};
		row.cfg  = 1'b1;
		row.addr = a;
		row.data = d;
		return row;
	endfunction

	function automatic logic [31:0] rand_pri();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(7);
			2: begin
				case ($urandom_range(3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom_range(32) - 32'd16;
		endcase
	endfunction

	function automatic logic [1:0] rand_kind(input int enq_pct, input int deq_pct);
		int r;
		r = $urandom_range(99);
		if (r < enq_pct)
			return REQ_ENQ;
		if (r < enq_pct + deq_pct)
			return REQ_DEQ;
		if (r < 97)
			return REQ_PEEK;
		return REQ_NONE;
	endfunction

	task automatic apb_cycle(input logic wr, input logic [ADDR_W-1:0] a, input logic [31:0] d,
		output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_cap(input logic [ADDR_W-1:0] a, input logic [31:0] d);
		logic [31:0] rd;
		wait_idle();
		apb_cycle(1'b1, a, d, rd);
		if (a[ADDR_W-1:2] == REG_CAP)
			cap_reg = d[7:0];
		apb_cycle(1'b0, ADDR_CAP, '0, rd);
		check_field("capacity_limit", {24'b0, cap_reg}, rd);
	endtask

	task automatic send_req(input logic [1:0] kind, input logic [31:0] v, input logic [31:0] p,
		input bit typed, input pq_result_t want);
		pq_result_t calc;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		value        <= v;
		priority_req <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		calc = predict_pq(kind, v, p);
		results_due.push_back(typed ? want : calc);
		kind_seen[kind]++;
	endtask

	task automatic run_phase(input int n, input int enq_pct, input int deq_pct);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_idle();
			send_req(rand_kind(enq_pct, deq_pct), $urandom(), rand_pri(), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			status_seen[status]++;
			if (results_due.size() == 0) begin
				$error("unexpected result beat: status %0d value 0x%08h", status, out_value);
				err_cnt++;
			end else begin
				due_front = results_due.pop_front();
				check_field("status", due_front.st, status);
				check_field("out_value", due_front.v, out_value);
				check_field("out_priority", due_front.p, out_priority);
				check_field("occupancy", due_front.occ, occupancy);
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cnt <= 0;
		else
			quiet_cnt <= quiet_cnt + 1;
		if (quiet_cnt >= LIMIT_CYCLES) begin
			$display("timeout: no beat for %0d cycles, %0d results outstanding",
				LIMIT_CYCLES, results_due.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [31:0] rd;
		directed.push_back(row_chk(REQ_PEEK, 0, 0, ST_EMPTY, 0, 0, 0));
		directed.push_back(row_chk(REQ_DEQ, 0, 0, ST_UNF, 0, 0, 0));
		directed.push_back(row_chk(REQ_NONE, '1, '1, ST_OK, 0, 0, 0));
		directed.push_back(row_chk(REQ_ENQ, 32'h7fff_ffff, 32'h8000_0000, ST_OK, 0, 0, 1));
		directed.push_back(row_chk(REQ_PEEK, 0, 0, ST_OK, 32'h7fff_ffff, 32'h8000_0000, 1));
		directed.push_back(row_req(REQ_ENQ, 32'h8000_0000, 32'h7fff_ffff));
		// equal priority stays below the root
		directed.push_back(row_req(REQ_ENQ, 32'h0000_0000, 32'h7fff_ffff));
		directed.push_back(row_req(REQ_ENQ, 32'h0000_0001, 32'd5));
		directed.push_back(row_req(REQ_ENQ, 32'h0000_0002, 32'd5));
		directed.push_back(row_req(REQ_PEEK, 32'h5555_5555, 32'haaaa_aaaa));
		directed.push_back(row_req(REQ_NONE, 32'h0000_1234, 32'h0000_5678));
		repeat (5) directed.push_back(row_req(REQ_DEQ, 32'haaaa_aaaa, 32'h5555_5555));
		directed.push_back(row_chk(REQ_DEQ, 0, 0, ST_UNF, 0, 0, 0));
		directed.push_back(row_cfg(ADDR_CAP, 32'd0));
		directed.push_back(row_chk(REQ_ENQ, 32'd5, 32'd5, ST_OVF, 0, 0, 0));
		directed.push_back(row_cfg(ADDR_SPARE, 32'd5));
		directed.push_back(row_chk(REQ_ENQ, 32'd6, 32'd6, ST_OVF, 0, 0, 0));
		directed.push_back(row_cfg(ADDR_CAP, 32'd1));
		directed.push_back(row_chk(REQ_ENQ, '1, '1, ST_OK, 0, 0, 1));
		directed.push_back(row_chk(REQ_ENQ, 32'd1, 32'd1, ST_OVF, 0, 0, 1));
		directed.push_back(row_chk(REQ_DEQ, 0, 0, ST_OK, '1, '1, 0));
		directed.push_back(row_cfg(ADDR_CAP, 32'd255));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_cycle(1'b0, ADDR_CAP, '0, rd);
		check_field("capacity_limit", {24'b0, CAP_RESET}, rd);

		foreach (directed[i]) begin
			if (directed[i].cfg)
				set_cap(directed[i].addr, directed[i].data);
			else
				send_req(directed[i].kind, directed[i].val, directed[i].pri,
					directed[i].typed, directed[i].want);
		end

		// fill past the full depth with no idling on either side
		idle_pct = 0;
		run_phase(170, 85, 5);
		idle_pct = 25;
		// capacity dropped under the current fill, upper data bits ignored
		set_cap(ADDR_CAP, 32'hffff_ff05);
		run_phase(60, 30, 60);
		set_cap(ADDR_CAP, 32'd128);
		run_phase(80, 45, 45);
		set_cap(ADDR_CAP, $urandom_range(127, 1));
		run_phase(70, 50, 40);
		set_cap(ADDR_CAP, {24'b0, CAP_RESET});
		run_phase(70, 10, 85);

		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("requests: %0d enqueue, %0d dequeue, %0d peek, %0d unused kind; peak fill %0d",
			kind_seen[REQ_ENQ], kind_seen[REQ_DEQ], kind_seen[REQ_PEEK], kind_seen[REQ_NONE],
			peak_held);
		$display("result status: %0d ok, %0d overflow, %0d underflow, %0d empty",
			status_seen[ST_OK], status_seen[ST_OVF], status_seen[ST_UNF], status_seen[ST_EMPTY]);
		if (err_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
